@@ rtl/core/size_class_pool_allocator_core_assert.svh @@
// Assertion macros of the allocator core module.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCPA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SCPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/scpa_pkg.sv @@
// Types, codes and defaults of the size class pool allocator.
package scpa_pkg;

  localparam int NUM_CLASSES          = 72;
  localparam int POOL_ADDR_BITS_DEF   = 16;
  localparam int HEADER_BYTES_DEF     = 12;
  localparam int ZONE_TABLE_BYTES_DEF = 1152;
  localparam int GUARD_BYTES          = 4;
  localparam int CLASS_W              = 7;
  localparam int ROUND_W              = 15;
  localparam int CFG_IDX_W            = 1;
  localparam int CFG_DATA_W           = 17;
  localparam int MAX_CHUNK            = 16384;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SIZE    = 3'd1,
    ST_OOM     = 3'd2,
    ST_RANGE   = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_ENABLE = 1'b0,
    CFG_POOL_BYTES  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_LINK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] req_size;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] user_addr;
  } rsp_t;

  // Size class lookup result handed from the sizer to the core
  typedef struct packed {
    logic               bad;
    logic [CLASS_W-1:0] cls;
    logic [ROUND_W-1:0] rounded;
  } class_info_t;

endpackage

@@ rtl/core/scpa_sizer.sv @@
// Chunk sizing and size class mapping for allocate requests.
module scpa_sizer #(
  parameter int HEADER_BYTES = scpa_pkg::HEADER_BYTES_DEF
) (
  input  logic [15:0]           req_size,
  output scpa_pkg::class_info_t info
);
  import scpa_pkg::*;

  logic [16:0]        need;
  logic [16:0]        raw;
  logic [3:0]         sh;
  logic [CLASS_W-1:0] base;
  logic [ROUND_W-1:0] sum;
  logic [4:0]         n;

  // Header, user bytes and two guards, rounded up to a word
  assign raw  = 17'(HEADER_BYTES) + 17'(req_size) + 17'(2 * GUARD_BYTES + 3);
  assign need = {raw[16:2], 2'b00};

  // Pick the class group from the leading bit of the chunk size
  always_comb begin
    priority if (need < 17'd128) begin
      sh = 4'd3; base = 7'd0;
    end else if (need < 17'd256) begin
      sh = 4'd4; base = 7'd8;
    end else if (need < 17'd512) begin
      sh = 4'd5; base = 7'd16;
    end else if (need < 17'd1024) begin
      sh = 4'd6; base = 7'd24;
    end else if (need < 17'd2048) begin
      sh = 4'd7; base = 7'd32;
    end else if (need < 17'd4096) begin
      sh = 4'd8; base = 7'd40;
    end else if (need < 17'd8192) begin
      sh = 4'd9; base = 7'd48;
    end else begin
      sh = 4'd10; base = 7'd56;
    end
  end

  // Round up within the group
  assign sum = need[ROUND_W-1:0] + ((ROUND_W'(1) << sh) - ROUND_W'(1));
  assign n   = 5'(sum >> sh);

  assign info.rounded = ROUND_W'(n) << sh;
  assign info.cls     = CLASS_W'(n) - CLASS_W'(1) + base;
  assign info.bad     = (req_size == 16'd0) || (need >= 17'(MAX_CHUNK));

endmodule

@@ rtl/core/size_class_pool_allocator_core.sv @@
// Top level of the size class pool allocator core.
// Each item (allocate, free or check) is taken when the core is idle. A
// request that fails in decode goes through decode, then result. A request
// that needs a read of the class table or the chunk header memory goes
// through decode, lookup and result. A free, or a list pop that leaves the
// list non-empty, adds a link step that writes the class table back; it
// also reads or writes the link memory, except for a free to an empty class.
// The memories have registered reads, and this chain of dependent accesses
// keeps the core busy: it returns to idle before the next item is taken, so
// it takes no new item before it is through with the last one. A result
// held by out_stall delays the next result item until it drains. After
// reset, and after a write of 1 to pool_enable while it is 0, the core
// sweeps the chunk header memory, and in_stall stays high meanwhile.
// Configuration writes are taken always.
module size_class_pool_allocator_core #(
  parameter int POOL_ADDR_BITS   = scpa_pkg::POOL_ADDR_BITS_DEF,
  parameter int HEADER_BYTES     = scpa_pkg::HEADER_BYTES_DEF,
  parameter int ZONE_TABLE_BYTES = scpa_pkg::ZONE_TABLE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  scpa_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scpa_pkg::rsp_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scpa_pkg::*;

  localparam int IW    = POOL_ADDR_BITS - 2;
  localparam int WORDS = 1 << IW;
  localparam int BW    = POOL_ADDR_BITS + 1;
  localparam int CW    = ((POOL_ADDR_BITS > 15) ? POOL_ADDR_BITS : 15) + 2;
  localparam int HW    = CLASS_W + 1;
  localparam int USER_OFS = HEADER_BYTES + GUARD_BYTES;

  // Control and payload registers
  state_e                 state, state_next;
  req_t                   req, req_next;
  logic [CLASS_W-1:0]     cls, cls_next;
  logic [ROUND_W-1:0]     rounded, rounded_next;
  logic [IW-1:0]          idx, idx_next;
  rsp_t                   rsp, rsp_next;
  rsp_t                   out_data_next;
  logic                   out_valid_next;
  logic                   pool_enable, pool_enable_next;
  logic [16:0]            pool_bytes, pool_bytes_next;
  logic [BW-1:0]          bump, bump_next;
  logic [NUM_CLASSES-1:0] head_valid, head_valid_next;
  logic [IW-1:0]          clr_cnt, clr_cnt_next;

  // Memory ports
  logic [HW-1:0]      hdr_mem [WORDS];
  logic               hdr_we, hdr_re;
  logic [IW-1:0]      hdr_waddr, hdr_raddr;
  logic [HW-1:0]      hdr_wdata, hdr_rdata;
  logic [2*IW-1:0]    cls_mem [NUM_CLASSES];
  logic               cls_we, cls_re;
  logic [CLASS_W-1:0] cls_waddr, cls_raddr;
  logic [2*IW-1:0]    cls_wdata, cls_rdata;
  logic [IW-1:0]      link_mem [WORDS];
  logic               link_we, link_re;
  logic [IW-1:0]      link_waddr, link_raddr, link_wdata, link_rdata;

  // Derived values
  class_info_t        info;
  logic [CW-1:0]      limit, cap, top_v, chunk_w, need_end, user_w;
  logic               addr_range, addr_bad;
  logic [IW-1:0]      aidx, head, tail, sel_idx;
  logic [CLASS_W-1:0] free_cls;
  logic               cfg_write;

  scpa_sizer #(.HEADER_BYTES(HEADER_BYTES)) u_sizer (
    .req_size (req.req_size),
    .info     (info)
  );

  // Pool limit: word aligned size, saturated at the address space
  assign cap   = CW'({pool_bytes[16:2], 2'b00});
  assign top_v = CW'(1) << POOL_ADDR_BITS;
  assign limit = (cap > top_v) ? top_v : cap;

  // Address checks for free and check
  assign chunk_w    = CW'(req.address) - CW'(USER_OFS);
  assign addr_range = CW'(req.address) >= limit;
  assign addr_bad   = (req.address < 16'(USER_OFS)) || (chunk_w[1:0] != 2'b00);
  assign aidx       = chunk_w[IW+1:2];

  assign head     = cls_rdata[2*IW-1:IW];
  assign tail     = cls_rdata[IW-1:0];
  assign need_end = CW'(bump) + CW'(rounded);
  assign free_cls = (hdr_rdata[CLASS_W-1:0] >= CLASS_W'(NUM_CLASSES)) ?
                    CLASS_W'(NUM_CLASSES - 1) : hdr_rdata[CLASS_W-1:0];
  assign sel_idx  = head_valid[cls] ? head : bump[IW+1:2];
  assign user_w   = CW'({sel_idx, 2'b00}) + CW'(USER_OFS);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Next state, memory accesses and register updates
  always_comb begin
    state_next      = state;
    req_next        = req;
    cls_next        = cls;
    rounded_next    = rounded;
    idx_next        = idx;
    rsp_next        = rsp;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    pool_enable_next = pool_enable;
    pool_bytes_next = pool_bytes;
    bump_next       = bump;
    head_valid_next = head_valid;
    clr_cnt_next    = clr_cnt;
    hdr_we = 1'b0; hdr_re = 1'b0; hdr_waddr = idx; hdr_raddr = aidx;
    hdr_wdata = '0;
    cls_we = 1'b0; cls_re = 1'b0; cls_waddr = cls; cls_raddr = info.cls;
    cls_wdata = '0;
    link_we = 1'b0; link_re = 1'b0; link_waddr = tail; link_raddr = head;
    link_wdata = idx;

    // Drain the output register
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_CLEAR: begin
        hdr_we       = 1'b1;
        hdr_waddr    = clr_cnt;
        clr_cnt_next = clr_cnt + IW'(1);
        if (clr_cnt == {IW{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_data;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cls_next     = info.cls;
        rounded_next = info.rounded;
        idx_next     = aidx;
        rsp_next     = '{status: ST_INVALID, user_addr: 16'd0};
        state_next   = S_RESULT;
        unique case (req.operation)
          OP_ALLOC: begin
            if (info.bad) begin
              rsp_next.status = ST_SIZE;
            end else if (pool_enable) begin
              cls_re     = 1'b1;
              state_next = S_LOOKUP;
            end
          end
          OP_FREE, OP_CHECK: begin
            if (pool_enable) begin
              if (addr_range) begin
                rsp_next.status = ST_RANGE;
              end else if (!addr_bad) begin
                hdr_re     = 1'b1;
                state_next = S_LOOKUP;
              end
            end
          end
          default: ;
        endcase
      end
      S_LOOKUP: begin
        state_next = S_RESULT;
        if (req.operation == OP_ALLOC) begin
          if (head_valid[cls] || need_end <= limit) begin
            // Pop the class list or cut from the bump region
            idx_next  = sel_idx;
            hdr_we    = 1'b1;
            hdr_waddr = sel_idx;
            hdr_wdata = {1'b1, cls};
            rsp_next  = '{status: ST_OK, user_addr: user_w[15:0]};
            if (!head_valid[cls]) begin
              bump_next = bump + BW'(rounded);
            end else if (head == tail) begin
              head_valid_next[cls] = 1'b0;
            end else begin
              link_re    = 1'b1;
              state_next = S_LINK;
            end
          end else begin
            rsp_next.status = ST_OOM;
          end
        end else if (!hdr_rdata[HW-1]) begin
          rsp_next.status = ST_INVALID;
        end else begin
          rsp_next.status = ST_OK;
          if (req.operation == OP_FREE) begin
            // Release the header and queue the chunk on its class
            cls_next   = free_cls;
            hdr_we     = 1'b1;
            cls_re     = 1'b1;
            cls_raddr  = free_cls;
            state_next = S_LINK;
          end
        end
      end
      S_LINK: begin
        state_next = S_RESULT;
        cls_we     = 1'b1;
        if (req.operation == OP_ALLOC) begin
          cls_wdata = {link_rdata, tail};
        end else if (head_valid[cls]) begin
          link_we   = 1'b1;
          cls_wdata = {head, idx};
        end else begin
          head_valid_next[cls] = 1'b1;
          cls_wdata = {idx, idx};
        end
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_data_next  = rsp;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Configuration writes; creating the pool starts a fresh clear
    if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_POOL_ENABLE: begin
          pool_enable_next = cfg_data[0];
          if (cfg_data[0] && !pool_enable) begin
            bump_next       = BW'(ZONE_TABLE_BYTES);
            head_valid_next = '0;
            clr_cnt_next    = '0;
            state_next      = S_CLEAR;
          end
        end
        CFG_POOL_BYTES: pool_bytes_next = cfg_data;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      out_valid   <= 1'b0;
      pool_enable <= 1'b0;
      pool_bytes  <= 17'h10000;
      bump        <= BW'(ZONE_TABLE_BYTES);
      head_valid  <= '0;
      clr_cnt     <= '0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      pool_enable <= pool_enable_next;
      pool_bytes  <= pool_bytes_next;
      bump        <= bump_next;
      head_valid  <= head_valid_next;
      clr_cnt     <= clr_cnt_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req      <= req_next;
    cls      <= cls_next;
    rounded  <= rounded_next;
    idx      <= idx_next;
    rsp      <= rsp_next;
    out_data <= out_data_next;
  end

  // Chunk header memory
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    if (hdr_re) begin
      hdr_rdata <= hdr_mem[hdr_raddr];
    end
  end

  // Class head and tail memory
  always_ff @(posedge clk) begin
    if (cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
    if (cls_re) begin
      cls_rdata <= cls_mem[cls_raddr];
    end
  end

  // Free list link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

`include "size_class_pool_allocator_core_assert.svh"

  `SCPA_ASSERT_IMPLY(a_clear_stalls, state == S_CLEAR, in_stall, "item taken during clear")
  `SCPA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state == S_DECODE, "accept lost")
  `SCPA_ASSERT_IMPLY(a_user_zero, out_valid && out_data.status != ST_OK,
                     out_data.user_addr == 16'd0, "address on failure")
  `SCPA_ASSERT_IMPLY(a_bump_bound, 1'b1, CW'(bump) <= top_v, "bump beyond pool")
  `SCPA_ASSERT_NEXT(a_result_held, out_valid && out_stall,
                    out_valid && $stable(out_data), "result dropped")

endmodule

@@ tb/tb_size_class_pool_allocator_core.sv @@
// Testbench of the size class pool allocator core: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_size_class_pool_allocator_core;
  import scpa_pkg::*;

  localparam int WORDS       = 1 << (POOL_ADDR_BITS_DEF - 2);
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  size_class_pool_allocator_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Allocator image kept by the predictor
  logic        pool_on;
  int unsigned pool_size;
  int unsigned bump_ptr;
  logic        head_live [NUM_CLASSES];
  logic [13:0] head_word [NUM_CLASSES];
  logic [13:0] tail_word [NUM_CLASSES];
  logic [13:0] next_word [WORDS];
  logic [15:0] hdr_mem [WORDS];

  rsp_t        expected_rsp[$];
  int unsigned live_addr[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void clear_image();
    bump_ptr = ZONE_TABLE_BYTES_DEF;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_live[c] = 1'b0;
      head_word[c] = '0;
      tail_word[c] = '0;
    end
    for (int w = 0; w < WORDS; w++) begin
      hdr_mem[w] = '0;
      next_word[w] = '0;
    end
  endfunction

  function automatic int unsigned usable_bytes();
    int unsigned cap;
    cap = pool_size & ~32'd3;
    return (cap > 65536) ? 65536 : cap;
  endfunction

  // Map a chunk size to its class; NUM_CLASSES marks a size too large
  function automatic int unsigned class_of(input int unsigned n, output int unsigned rounded);
    int unsigned sh, base, q;
    sh = 3; base = 0;
    if (n >= 16384) begin
      rounded = n;
      return NUM_CLASSES;
    end
    for (int k = 0; k < 7; k++)
      if (n >= (128 << k)) begin
        sh = 4 + k;
        base = 8 * (k + 1);
      end
    q = (n + (1 << sh) - 1) >> sh;
    rounded = q << sh;
    return q - 1 + base;
  endfunction

  function automatic void drop_live(input int unsigned a);
    for (int i = 0; i < live_addr.size(); i++)
      if (live_addr[i] == a) begin
        live_addr.delete(i);
        return;
      end
  endfunction

  // Compute the result of one request and advance the image
  function automatic rsp_t predict_rsp(input req_t r);
    rsp_t        o;
    int unsigned need, rounded, cls, chunk, w;
    o.status = ST_OK;
    o.user_addr = '0;
    w = 0;
    case (op_e'(r.operation))
      OP_ALLOC: begin
        need = (HEADER_BYTES_DEF + r.req_size + 2 * GUARD_BYTES + 3) & ~32'd3;
        cls = class_of(need, rounded);
        if (r.req_size == 0 || cls >= NUM_CLASSES) o.status = ST_SIZE;
        else if (!pool_on) o.status = ST_INVALID;
        else begin
          if (head_live[cls]) begin
            w = 32'(head_word[cls]);
            if (head_word[cls] == tail_word[cls]) head_live[cls] = 1'b0;
            else head_word[cls] = next_word[w];
          end else if (bump_ptr + rounded > usable_bytes()) begin
            o.status = ST_OOM;
          end else begin
            w = (bump_ptr >> 2) & (WORDS - 1);
            bump_ptr += rounded;
          end
          if (o.status == ST_OK) begin
            hdr_mem[w] = 16'h8000 | cls[15:0];
            o.user_addr = 16'((w << 2) + HEADER_BYTES_DEF + GUARD_BYTES);
            live_addr.push_back(o.user_addr);
          end
        end
      end
      OP_FREE, OP_CHECK: begin
        if (!pool_on) o.status = ST_INVALID;
        else if (r.address >= usable_bytes()) o.status = ST_RANGE;
        else if (r.address < HEADER_BYTES_DEF + GUARD_BYTES) o.status = ST_INVALID;
        else begin
          chunk = r.address - HEADER_BYTES_DEF - GUARD_BYTES;
          w = (chunk >> 2) & (WORDS - 1);
          if ((chunk & 3) != 0 || !hdr_mem[w][15]) o.status = ST_INVALID;
          else if (op_e'(r.operation) == OP_FREE) begin
            cls = 32'(hdr_mem[w] & 16'h7F);
            if (cls >= NUM_CLASSES) cls = NUM_CLASSES - 1;
            hdr_mem[w] = '0;
            if (!head_live[cls]) begin
              head_live[cls] = 1'b1;
              head_word[cls] = 14'(w);
            end else next_word[tail_word[cls]] = 14'(w);
            tail_word[cls] = 14'(w);
            drop_live(r.address);
          end
        end
      end
      default: o.status = ST_INVALID;
    endcase
    return o;
  endfunction

  // Drive back-pressure on the result side
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) report_mismatch("unexpected result", out_data.status, -1);
      else begin
        if (out_data.status !== expected_rsp[0].status)
          report_mismatch("status", out_data.status, expected_rsp[0].status);
        if (out_data.user_addr !== expected_rsp[0].user_addr)
          report_mismatch("user_addr", out_data.user_addr, expected_rsp[0].user_addr);
        void'(expected_rsp.pop_front());
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_size_class_pool_allocator_core: errors");
      $finish;
    end
  end

  task automatic send_req(input op_e op, input int unsigned size, input int unsigned addr);
    req_t r;
    r.operation = op;
    r.req_size = size[15:0];
    r.address = addr[15:0];
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_rsp.push_back(predict_rsp(r));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
  endtask

  // Hold until every expected item has come and the core has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_POOL_ENABLE) begin
      if (value[0] && !pool_on) begin
        clear_image();
        live_addr.delete();
      end
      pool_on = value[0];
    end else pool_size = value & 32'h1FFFF;
  endtask

  task automatic fresh_pool(input int unsigned bytes);
    write_reg(CFG_POOL_ENABLE, 0);
    write_reg(CFG_POOL_BYTES, bytes);
    write_reg(CFG_POOL_ENABLE, 1);
  endtask

  task automatic test_disabled_pool();
    send_req(OP_ALLOC, 16, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_FREE, 0, 100);
    send_req(OP_CHECK, 0, 65535);
  endtask

  task automatic test_size_limits();
    fresh_pool(131071);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_ALLOC, 16360, 0);
    send_req(OP_ALLOC, 16361, 0);
    send_req(OP_ALLOC, 65535, 0);
    send_req(OP_ALLOC, 0, 65535);
  endtask

  task automatic test_free_and_reuse();
    int unsigned a;
    a = ZONE_TABLE_BYTES_DEF + HEADER_BYTES_DEF + GUARD_BYTES;
    send_req(OP_CHECK, 0, a);
    send_req(OP_FREE, 0, a);
    send_req(OP_FREE, 0, a);
    send_req(OP_CHECK, 0, a);
    send_req(OP_ALLOC, 2, 0);
    send_req(OP_CHECK, 0, a);
  endtask

  task automatic test_bad_addresses();
    send_req(OP_FREE, 0, 65535);
    send_req(OP_CHECK, 0, 0);
    send_req(OP_FREE, 0, ZONE_TABLE_BYTES_DEF + 21);
    send_req(OP_CHECK, 0, 20);
    send_req(OP_BAD, 65535, 65535);
  endtask

  task automatic test_shrunk_pool();
    int unsigned a;
    a = ZONE_TABLE_BYTES_DEF + HEADER_BYTES_DEF + GUARD_BYTES;
    send_req(OP_FREE, 0, a);
    write_reg(CFG_POOL_BYTES, 1156);
    send_req(OP_ALLOC, 100, 0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_CHECK, 0, 2000);
    write_reg(CFG_POOL_BYTES, 65536);
  endtask

  // Mostly well-formed alloc/free/check traffic on live chunks, some noise
  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    int unsigned pick, sz;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        sz = ($urandom_range(19) == 0) ? $urandom_range(16360, 1) : $urandom_range(600, 1);
        send_req(OP_ALLOC, sz, $urandom());
      end else if (pick < 75 && live_addr.size() != 0)
        send_req(OP_FREE, $urandom(), live_addr[$urandom_range(live_addr.size() - 1)]);
      else if (pick < 88 && live_addr.size() != 0)
        send_req(OP_CHECK, $urandom(), live_addr[$urandom_range(live_addr.size() - 1)]);
      else
        send_req(op_e'($urandom_range(3)), $urandom(), $urandom());
    end
    drain();
  endtask

  initial begin
    pool_on = 1'b0;
    pool_size = 65536;
    clear_image();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_disabled_pool();
    test_size_limits();
    test_free_and_reuse();
    test_bad_addresses();
    test_shrunk_pool();
    test_random(110, 0, 0);
    test_random(100, 83, 0);
    fresh_pool(8192);
    test_random(100, 0, 83);
    fresh_pool(1156);
    test_random(20, 13, 13);
    fresh_pool(65536);
    test_random(90, 13, 13);
    drain();
    if (errors == 0) $display("tb_size_class_pool_allocator_core: clean");
    else $display("tb_size_class_pool_allocator_core: errors");
    $finish;
  end

endmodule
